FILE: rtl/core/fee_pkg.sv
// Shared types, codes and constants of the formula expression evaluator.
package fee_pkg;

  localparam int OSD_DEF = 16;
  localparam int VSD_DEF = 16;
  localparam int VB_DEF  = 32;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] PREC_PAREN = 2'd0;
  localparam logic [1:0] PREC_ADD   = 2'd2;
  localparam logic [1:0] PREC_MUL   = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LPAREN
  } op_t;

  typedef enum logic [2:0] {
    PH_START, PH_PLAIN, PH_RANGE_LO, PH_RANGE_HI, PH_SELECTED, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_CHAR, ERR_BRACKET, ERR_MALFORMED, ERR_DIV0, ERR_OVERFLOW, ERR_PIECE
  } err_t;

  typedef enum logic [1:0] {
    FIN_LO, FIN_HI, FIN_SEL, FIN_LAST
  } fin_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHAR, S_OPCHAR, S_PREC_RD, S_PREC_CHK, S_OPPUSH, S_RP_RD, S_RP_CHK,
    S_FIN, S_FIN_RD, S_FIN_POP, S_FIN_CHK, S_FIN_VAL, S_AP, S_AP_B, S_AP_A,
    S_AP_WAIT, S_END, S_LAST_VAL, S_EMIT
  } seq_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_FIX, A_DONE
  } alu_st_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div0;
  } alu_rsp_t;

  function automatic logic [1:0] prec(op_t op);
    if (op == OP_LPAREN) begin
      return PREC_PAREN;
    end
    return (op == OP_MUL || op == OP_DIV) ? PREC_MUL : PREC_ADD;
  endfunction

endpackage

FILE: rtl/core/fee_if.sv
// Valid/ready channel interfaces for formula characters and results.
interface fee_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        last_char;
  logic [15:0] wire_index;
  logic [15:0] channel_width;

  modport source (output valid, char_code, last_char, wire_index, channel_width,
                  input ready);
  modport sink (input valid, char_code, last_char, wire_index, channel_width,
                output ready);
endinterface

interface fee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         error_code;

  modport source (output valid, value, error_code, input ready);
  modport sink (input valid, value, error_code, output ready);
endinterface

FILE: rtl/core/fee_alu.sv
// Shared arithmetic unit: registered add/subtract, bit-serial multiply and divide.
module fee_alu #(
  parameter int VB = fee_pkg::VB_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fee_pkg::alu_req_t req,
  input  logic [VB-1:0]     a,
  input  logic [VB-1:0]     b,
  output fee_pkg::alu_rsp_t rsp,
  output logic [VB-1:0]     res
);

  localparam int CW = $clog2(VB);

  fee_pkg::alu_st_t st_r, st_nxt;
  logic [VB-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt, rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, div0_r, div0_nxt;
  logic [VB:0]   rem_sh, diff;
  logic          ge;

  assign rem_sh = {rem_r, x_r[VB-1]};
  assign diff   = rem_sh - {1'b0, y_r};
  assign ge     = ~diff[VB];

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    div0_nxt = div0_r;
    unique case (st_r)
      fee_pkg::A_IDLE: begin
        if (req.start) begin
          div0_nxt = 1'b0;
          cnt_nxt  = CW'(VB - 1);
          unique case (req.op)
            fee_pkg::OP_ADD: begin
              acc_nxt = a + b;
              st_nxt  = fee_pkg::A_DONE;
            end
            fee_pkg::OP_SUB: begin
              acc_nxt = a - b;
              st_nxt  = fee_pkg::A_DONE;
            end
            fee_pkg::OP_MUL: begin
              acc_nxt = '0;
              x_nxt   = a;
              y_nxt   = b;
              st_nxt  = fee_pkg::A_MUL;
            end
            fee_pkg::OP_DIV: begin
              if (b == '0) begin
                div0_nxt = 1'b1;
                st_nxt   = fee_pkg::A_DONE;
              end else begin
                neg_nxt = a[VB-1] ^ b[VB-1];
                x_nxt   = a[VB-1] ? -a : a;
                y_nxt   = b[VB-1] ? -b : b;
                rem_nxt = '0;
                st_nxt  = fee_pkg::A_DIV;
              end
            end
            default: begin
              acc_nxt = '0;
              st_nxt  = fee_pkg::A_DONE;
            end
          endcase
        end
      end
      fee_pkg::A_MUL: begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt   = {x_r[VB-2:0], 1'b0};
        y_nxt   = {1'b0, y_r[VB-1:1]};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          st_nxt = fee_pkg::A_DONE;
        end
      end
      fee_pkg::A_DIV: begin
        rem_nxt = ge ? diff[VB-1:0] : rem_sh[VB-1:0];
        x_nxt   = {x_r[VB-2:0], ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          st_nxt = fee_pkg::A_FIX;
        end
      end
      fee_pkg::A_FIX: begin
        acc_nxt = neg_r ? -x_r : x_r;
        st_nxt  = fee_pkg::A_DONE;
      end
      fee_pkg::A_DONE: begin
        st_nxt = fee_pkg::A_IDLE;
      end
      default: begin
        st_nxt = fee_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= fee_pkg::A_IDLE;
      div0_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      div0_r <= div0_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = (st_r == fee_pkg::A_DONE);
  assign rsp.div0 = div0_r;
  assign res      = acc_r;

endmodule

FILE: rtl/core/formula_expression_evaluator_core.sv
// Top level: character sequencer, operator and value stacks, shared arithmetic unit.
// Takes one formula character per word and returns one result word after the character
// marked last. The block accepts nothing while a character is in work. Each operator
// that leaves the operator stack reads its two operands from the value stack memory,
// which gives one operand a cycle, and waits for the shared arithmetic unit, which
// multiplies and divides one bit a cycle. The character marked last also pops the
// operators still stacked, and more waiting follows while the previous result still
// waits. A finished result waits in an output register, so the next formula may start
// before it is taken.
module formula_expression_evaluator_core #(
  parameter int OPERATOR_STACK_DEPTH = fee_pkg::OSD_DEF,
  parameter int VALUE_STACK_DEPTH    = fee_pkg::VSD_DEF,
  parameter int VALUE_BITS           = fee_pkg::VB_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fee_in_if.sink     in_ch,
  fee_out_if.source  out_ch
);

  localparam int VB  = VALUE_BITS;
  localparam int OAW = $clog2(OPERATOR_STACK_DEPTH);
  localparam int OCW = $clog2(OPERATOR_STACK_DEPTH + 1);
  localparam int VAW = $clog2(VALUE_STACK_DEPTH);
  localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);

  fee_pkg::seq_t   st_r, st_nxt, ret_r, ret_nxt;
  fee_pkg::phase_t phase_r, phase_nxt;
  fee_pkg::err_t   err_r, err_nxt;
  fee_pkg::fin_t   fin_r, fin_nxt;
  fee_pkg::op_t    op_r, op_nxt, apop_r, apop_nxt;
  logic [OCW-1:0]  ocnt_r, ocnt_nxt, ocnt_m1;
  logic [VCW-1:0]  vcnt_r, vcnt_nxt, vcnt_m1, vcnt_m2;
  logic [VB-1:0]   acc_r, acc_nxt, rlo_r, rlo_nxt, b_r, b_nxt, res_r, res_nxt;
  logic            inlit_r, inlit_nxt, last_r, last_nxt;
  logic [15:0]     t_r, t_nxt, w_r, w_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic            ov_r, ov_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [2:0]      oerr_r, oerr_nxt;

  fee_pkg::op_t    omem [OPERATOR_STACK_DEPTH];
  fee_pkg::op_t    ord_r;
  logic [VB-1:0]   vmem [VALUE_STACK_DEPTH];
  logic [VB-1:0]   vrd_r;

  logic            owe, vwe;
  logic [OAW-1:0]  owa;
  fee_pkg::op_t    owd;
  logic [VAW-1:0]  vwa, vra;
  logic [VB-1:0]   vwd;

  fee_pkg::alu_req_t alu_req;
  fee_pkg::alu_rsp_t alu_rsp;
  logic [VB-1:0]     alu_res;

  logic is_digit, delim_fin, expr_phase, in_acc;
  logic signed [VB-1:0] lo_s, hi_s, t_s;
  logic signed [63:0]   ext;

  assign ocnt_m1  = ocnt_r - OCW'(1);
  assign vcnt_m1  = vcnt_r - VCW'(1);
  assign vcnt_m2  = vcnt_r - VCW'(2);
  assign is_digit = (ch_r >= fee_pkg::CH_ZERO) && (ch_r <= fee_pkg::CH_NINE);
  assign delim_fin = (phase_r == fee_pkg::PH_RANGE_LO && ch_r == fee_pkg::CH_COLON) ||
                     (phase_r == fee_pkg::PH_RANGE_HI && ch_r == fee_pkg::CH_RBRACE) ||
                     (phase_r == fee_pkg::PH_SELECTED && ch_r == fee_pkg::CH_SEMI);
  assign expr_phase = (phase_r == fee_pkg::PH_PLAIN) || (phase_r == fee_pkg::PH_RANGE_LO) ||
                      (phase_r == fee_pkg::PH_RANGE_HI) || (phase_r == fee_pkg::PH_SELECTED);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign lo_s     = $signed(rlo_r);
  assign hi_s     = $signed(vrd_r);
  assign t_s      = $signed(VB'(t_r));
  assign ext      = 64'($signed(res_r));

  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    apop_nxt  = apop_r;
    ocnt_nxt  = ocnt_r;
    vcnt_nxt  = vcnt_r;
    acc_nxt   = acc_r;
    rlo_nxt   = rlo_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    inlit_nxt = inlit_r;
    last_nxt  = last_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    ch_nxt    = ch_r;
    ov_nxt    = ov_r && !out_ch.ready;
    oval_nxt  = oval_r;
    oerr_nxt  = oerr_r;
    owe       = 1'b0;
    owa       = ocnt_r[OAW-1:0];
    owd       = op_r;
    vwe       = 1'b0;
    vwa       = vcnt_r[VAW-1:0];
    vwd       = acc_r;
    vra       = vcnt_m1[VAW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = apop_r;
    unique case (st_r)
      fee_pkg::S_IDLE: begin
        if (in_acc) begin
          ch_nxt   = in_ch.char_code;
          last_nxt = in_ch.last_char;
          st_nxt   = fee_pkg::S_CHAR;
          if (phase_r == fee_pkg::PH_START) begin
            t_nxt     = in_ch.wire_index;
            w_nxt     = in_ch.channel_width;
            ocnt_nxt  = '0;
            vcnt_nxt  = '0;
            inlit_nxt = 1'b0;
            acc_nxt   = '0;
            if (in_ch.char_code == fee_pkg::CH_LBRACE) begin
              phase_nxt = fee_pkg::PH_RANGE_LO;
              st_nxt    = fee_pkg::S_END;
            end else begin
              phase_nxt = fee_pkg::PH_PLAIN;
            end
          end
        end
      end
      fee_pkg::S_CHAR: begin
        st_nxt = fee_pkg::S_END;
        if (err_r != fee_pkg::ERR_NONE) begin
          st_nxt = fee_pkg::S_END;
        end else if (delim_fin) begin
          fin_nxt = (phase_r == fee_pkg::PH_RANGE_LO) ? fee_pkg::FIN_LO :
                    (phase_r == fee_pkg::PH_RANGE_HI) ? fee_pkg::FIN_HI : fee_pkg::FIN_SEL;
          st_nxt  = fee_pkg::S_FIN;
        end else if (expr_phase) begin
          if (is_digit) begin
            acc_nxt   = ((inlit_r ? acc_r : '0) << 3) + ((inlit_r ? acc_r : '0) << 1) +
                        VB'(ch_r[3:0]);
            inlit_nxt = 1'b1;
          end else begin
            st_nxt = fee_pkg::S_OPCHAR;
            if (inlit_r) begin
              inlit_nxt = 1'b0;
              acc_nxt   = '0;
              if (vcnt_r >= VCW'(VALUE_STACK_DEPTH)) begin
                err_nxt = fee_pkg::ERR_OVERFLOW;
                st_nxt  = fee_pkg::S_END;
              end else begin
                vwe      = 1'b1;
                vcnt_nxt = vcnt_r + VCW'(1);
              end
            end
          end
        end else if (phase_r == fee_pkg::PH_SKIP && ch_r == fee_pkg::CH_LBRACE) begin
          ocnt_nxt  = '0;
          vcnt_nxt  = '0;
          inlit_nxt = 1'b0;
          acc_nxt   = '0;
          phase_nxt = fee_pkg::PH_RANGE_LO;
        end
      end
      fee_pkg::S_OPCHAR: begin
        st_nxt = fee_pkg::S_END;
        unique case (ch_r)
          fee_pkg::CH_SPACE: ;
          fee_pkg::CH_T, fee_pkg::CH_W: begin
            vwd = (ch_r == fee_pkg::CH_T) ? VB'(t_r) : VB'(w_r);
            if (vcnt_r >= VCW'(VALUE_STACK_DEPTH)) begin
              err_nxt = fee_pkg::ERR_OVERFLOW;
            end else begin
              vwe      = 1'b1;
              vcnt_nxt = vcnt_r + VCW'(1);
            end
          end
          fee_pkg::CH_PLUS: begin
            op_nxt = fee_pkg::OP_ADD;
            st_nxt = fee_pkg::S_PREC_RD;
          end
          fee_pkg::CH_MINUS: begin
            op_nxt = fee_pkg::OP_SUB;
            st_nxt = fee_pkg::S_PREC_RD;
          end
          fee_pkg::CH_STAR: begin
            op_nxt = fee_pkg::OP_MUL;
            st_nxt = fee_pkg::S_PREC_RD;
          end
          fee_pkg::CH_SLASH: begin
            op_nxt = fee_pkg::OP_DIV;
            st_nxt = fee_pkg::S_PREC_RD;
          end
          fee_pkg::CH_LPAR: begin
            owd = fee_pkg::OP_LPAREN;
            if (ocnt_r >= OCW'(OPERATOR_STACK_DEPTH)) begin
              err_nxt = fee_pkg::ERR_OVERFLOW;
            end else begin
              owe      = 1'b1;
              ocnt_nxt = ocnt_r + OCW'(1);
            end
          end
          fee_pkg::CH_RPAR: begin
            st_nxt = fee_pkg::S_RP_RD;
          end
          default: begin
            err_nxt = fee_pkg::ERR_CHAR;
          end
        endcase
      end
      fee_pkg::S_PREC_RD: begin
        st_nxt = (ocnt_r == '0) ? fee_pkg::S_OPPUSH : fee_pkg::S_PREC_CHK;
      end
      fee_pkg::S_PREC_CHK: begin
        if (ord_r == fee_pkg::OP_LPAREN || fee_pkg::prec(ord_r) < fee_pkg::prec(op_r)) begin
          st_nxt = fee_pkg::S_OPPUSH;
        end else begin
          ocnt_nxt = ocnt_m1;
          apop_nxt = ord_r;
          ret_nxt  = fee_pkg::S_PREC_RD;
          st_nxt   = fee_pkg::S_AP;
        end
      end
      fee_pkg::S_OPPUSH: begin
        st_nxt = fee_pkg::S_END;
        if (ocnt_r >= OCW'(OPERATOR_STACK_DEPTH)) begin
          err_nxt = fee_pkg::ERR_OVERFLOW;
        end else begin
          owe      = 1'b1;
          ocnt_nxt = ocnt_r + OCW'(1);
        end
      end
      fee_pkg::S_RP_RD: begin
        if (ocnt_r == '0) begin
          err_nxt = fee_pkg::ERR_BRACKET;
          st_nxt  = fee_pkg::S_END;
        end else begin
          st_nxt = fee_pkg::S_RP_CHK;
        end
      end
      fee_pkg::S_RP_CHK: begin
        ocnt_nxt = ocnt_m1;
        if (ord_r == fee_pkg::OP_LPAREN) begin
          st_nxt = fee_pkg::S_END;
        end else begin
          apop_nxt = ord_r;
          ret_nxt  = fee_pkg::S_RP_RD;
          st_nxt   = fee_pkg::S_AP;
        end
      end
      fee_pkg::S_FIN: begin
        st_nxt = fee_pkg::S_FIN_RD;
        if (inlit_r) begin
          inlit_nxt = 1'b0;
          acc_nxt   = '0;
          if (vcnt_r >= VCW'(VALUE_STACK_DEPTH)) begin
            err_nxt = fee_pkg::ERR_OVERFLOW;
          end else begin
            vwe      = 1'b1;
            vcnt_nxt = vcnt_r + VCW'(1);
          end
        end
      end
      fee_pkg::S_FIN_RD: begin
        if (err_r != fee_pkg::ERR_NONE) begin
          st_nxt = fee_pkg::S_END;
        end else if (ocnt_r == '0) begin
          st_nxt = fee_pkg::S_FIN_CHK;
        end else begin
          st_nxt = fee_pkg::S_FIN_POP;
        end
      end
      fee_pkg::S_FIN_POP: begin
        ocnt_nxt = ocnt_m1;
        if (ord_r == fee_pkg::OP_LPAREN) begin
          err_nxt = fee_pkg::ERR_BRACKET;
          st_nxt  = fee_pkg::S_END;
        end else begin
          apop_nxt = ord_r;
          ret_nxt  = fee_pkg::S_FIN_RD;
          st_nxt   = fee_pkg::S_AP;
        end
      end
      fee_pkg::S_FIN_CHK: begin
        vra = '0;
        if (vcnt_r != VCW'(1)) begin
          err_nxt = fee_pkg::ERR_MALFORMED;
          st_nxt  = fee_pkg::S_END;
        end else begin
          st_nxt = fee_pkg::S_FIN_VAL;
        end
      end
      fee_pkg::S_FIN_VAL: begin
        st_nxt = fee_pkg::S_END;
        unique case (fin_r)
          fee_pkg::FIN_LO, fee_pkg::FIN_HI: begin
            ocnt_nxt  = '0;
            vcnt_nxt  = '0;
            inlit_nxt = 1'b0;
            acc_nxt   = '0;
            if (fin_r == fee_pkg::FIN_LO) begin
              rlo_nxt   = vrd_r;
              phase_nxt = fee_pkg::PH_RANGE_HI;
            end else if (lo_s > hi_s) begin
              err_nxt = fee_pkg::ERR_PIECE;
            end else if (lo_s <= t_s && t_s <= hi_s) begin
              phase_nxt = fee_pkg::PH_SELECTED;
            end else begin
              phase_nxt = fee_pkg::PH_SKIP;
            end
          end
          fee_pkg::FIN_SEL: begin
            phase_nxt = fee_pkg::PH_DONE;
          end
          default: begin
            res_nxt = vrd_r;
            st_nxt  = fee_pkg::S_EMIT;
          end
        endcase
      end
      fee_pkg::S_AP: begin
        if (vcnt_r < VCW'(2)) begin
          err_nxt = fee_pkg::ERR_MALFORMED;
          st_nxt  = fee_pkg::S_END;
        end else begin
          st_nxt = fee_pkg::S_AP_B;
        end
      end
      fee_pkg::S_AP_B: begin
        b_nxt  = vrd_r;
        vra    = vcnt_m2[VAW-1:0];
        st_nxt = fee_pkg::S_AP_A;
      end
      fee_pkg::S_AP_A: begin
        vcnt_nxt      = vcnt_m2;
        alu_req.start = 1'b1;
        st_nxt        = fee_pkg::S_AP_WAIT;
      end
      fee_pkg::S_AP_WAIT: begin
        vwd = alu_res;
        if (alu_rsp.done) begin
          if (alu_rsp.div0) begin
            err_nxt = fee_pkg::ERR_DIV0;
            st_nxt  = fee_pkg::S_END;
          end else if (vcnt_r >= VCW'(VALUE_STACK_DEPTH)) begin
            err_nxt = fee_pkg::ERR_OVERFLOW;
            st_nxt  = fee_pkg::S_END;
          end else begin
            vwe      = 1'b1;
            vcnt_nxt = vcnt_r + VCW'(1);
            st_nxt   = ret_r;
          end
        end
      end
      fee_pkg::S_END: begin
        vra = '0;
        if (!last_r) begin
          st_nxt = fee_pkg::S_IDLE;
        end else if (err_r != fee_pkg::ERR_NONE) begin
          st_nxt = fee_pkg::S_EMIT;
        end else if (phase_r == fee_pkg::PH_PLAIN || phase_r == fee_pkg::PH_SELECTED) begin
          fin_nxt = fee_pkg::FIN_LAST;
          st_nxt  = fee_pkg::S_FIN;
        end else if (phase_r == fee_pkg::PH_DONE) begin
          st_nxt = fee_pkg::S_LAST_VAL;
        end else begin
          err_nxt = fee_pkg::ERR_PIECE;
          st_nxt  = fee_pkg::S_EMIT;
        end
      end
      fee_pkg::S_LAST_VAL: begin
        res_nxt = vrd_r;
        st_nxt  = fee_pkg::S_EMIT;
      end
      fee_pkg::S_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oval_nxt  = (err_r != fee_pkg::ERR_NONE) ? 32'sd0 : ext[31:0];
          oerr_nxt  = err_r;
          phase_nxt = fee_pkg::PH_START;
          err_nxt   = fee_pkg::ERR_NONE;
          ocnt_nxt  = '0;
          vcnt_nxt  = '0;
          inlit_nxt = 1'b0;
          acc_nxt   = '0;
          rlo_nxt   = '0;
          t_nxt     = '0;
          w_nxt     = '0;
          st_nxt    = fee_pkg::S_IDLE;
        end
      end
      default: begin
        st_nxt = fee_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ch.ready       = (st_r == fee_pkg::S_IDLE);
    out_ch.valid      = ov_r;
    out_ch.value      = oval_r;
    out_ch.error_code = oerr_r;
  end

  always_ff @(posedge clk) begin
    if (owe) begin
      omem[owa] <= owd;
    end
    ord_r <= omem[ocnt_m1[OAW-1:0]];
    if (vwe) begin
      vmem[vwa] <= vwd;
    end
    vrd_r <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= fee_pkg::S_IDLE;
      phase_r <= fee_pkg::PH_START;
      err_r   <= fee_pkg::ERR_NONE;
      ocnt_r  <= '0;
      vcnt_r  <= '0;
      acc_r   <= '0;
      inlit_r <= 1'b0;
      rlo_r   <= '0;
      t_r     <= '0;
      w_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      ocnt_r  <= ocnt_nxt;
      vcnt_r  <= vcnt_nxt;
      acc_r   <= acc_nxt;
      inlit_r <= inlit_nxt;
      rlo_r   <= rlo_nxt;
      t_r     <= t_nxt;
      w_r     <= w_nxt;
      ov_r    <= ov_nxt;
    end
    ret_r  <= ret_nxt;
    fin_r  <= fin_nxt;
    op_r   <= op_nxt;
    apop_r <= apop_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    last_r <= last_nxt;
    ch_r   <= ch_nxt;
    oval_r <= oval_nxt;
    oerr_r <= oerr_nxt;
  end

  fee_alu #(
    .VB(VB)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (vrd_r),
    .b     (b_r),
    .rsp   (alu_rsp),
    .res   (alu_res)
  );

endmodule

FILE: rtl/core/fee_checker.sv
// Port-level assertions for the formula expression evaluator, bound to the top level.
module fee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [2:0]  out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error_code))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("character accepted while previous one in work");

  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != fee_pkg::ERR_NONE |-> out_value == 32'd0)
    else $error("nonzero value with error code");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= fee_pkg::ERR_PIECE)
    else $error("undefined error code");

endmodule

bind formula_expression_evaluator_core fee_checker u_fee_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_error_code (out_ch.error_code)
);
